@@ sv/lts_pkg.sv @@
// Package: shared constants, types and date tables for the log timestamp scanner.
package lts_pkg;

  localparam int WinLen  = 19;
  localparam int FracMax = 6;

  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic signed [20:0] EpochDays = 21'sd719468;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic                ok;
    logic [6:0]          yr_hi;
    logic [6:0]          yr_lo;
    logic signed [20:0]  day_adj;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
  } date_info_t;

  function automatic logic [4:0] month_days(input logic [6:0] mo, input logic leap);
    logic [4:0] r;
    r = 5'd31;
    case (mo)
      7'd2:    r = leap ? 5'd29 : 5'd28;
      7'd4:    r = 5'd30;
      7'd6:    r = 5'd30;
      7'd9:    r = 5'd30;
      7'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // days before the month, year counted from March
  function automatic logic [8:0] month_base(input logic [6:0] mo);
    logic [8:0] r;
    r = 9'd0;
    case (mo)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [19:0] frac_scale(input logic [2:0] digits);
    logic [19:0] r;
    r = 20'd0;
    case (digits)
      3'd0:    r = 20'd1000000;
      3'd1:    r = 20'd100000;
      3'd2:    r = 20'd10000;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd100;
      3'd5:    r = 20'd10;
      3'd6:    r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/lts_if.sv @@
// Interfaces: text byte input channel and timestamp result channel.
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;
  modport source (output valid, text_byte, line_end, input ready);
  modport sink (input valid, text_byte, line_end, output ready);
endinterface

interface lts_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [58:0] timestamp_us;
  modport source (output valid, found, timestamp_us, input ready);
  modport sink (input valid, found, timestamp_us, output ready);
endinterface

@@ sv/lts_date_check.sv @@
// Date check: window shape, field validity and day-count terms.
module lts_date_check (
  input  lts_pkg::byte_t      win [lts_pkg::WinLen],
  output lts_pkg::date_info_t info
);
  import lts_pkg::*;

  logic [3:0]  dg [WinLen];
  logic [WinLen-1:0] isd;
  logic        shape, alldig, leap, early;
  logic [6:0]  yh, yl, mo, dd, hh, mi, ss, h_adj, l_adj;
  logic signed [20:0] adj;

  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      isd[i] = (win[i] >= ChZero) && (win[i] <= ChNine);
      dg[i]  = 4'(win[i] - ChZero);
    end
    shape = (win[4] == ChDash) && (win[7] == ChDash) && (win[10] == ChSpace) &&
            (win[13] == ChColon) && (win[16] == ChColon);
    alldig = isd[0] && isd[1] && isd[2] && isd[3] && isd[5] && isd[6] && isd[8] &&
             isd[9] && isd[11] && isd[12] && isd[14] && isd[15] && isd[17] && isd[18];
    yh = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
    yl = 7'(dg[2]) * 7'd10 + 7'(dg[3]);
    mo = 7'(dg[5]) * 7'd10 + 7'(dg[6]);
    dd = 7'(dg[8]) * 7'd10 + 7'(dg[9]);
    hh = 7'(dg[11]) * 7'd10 + 7'(dg[12]);
    mi = 7'(dg[14]) * 7'd10 + 7'(dg[15]);
    ss = 7'(dg[17]) * 7'd10 + 7'(dg[18]);
    leap = (yl != 7'd0) ? (yl[1:0] == 2'd0) : (yh[1:0] == 2'd0);
    early = (mo <= 7'd2);
    h_adj = yh;
    l_adj = yl;
    if (early) begin
      if (yl == 7'd0) begin
        h_adj = yh - 7'd1;
        l_adj = 7'd99;
      end else begin
        l_adj = yl - 7'd1;
      end
    end
    adj = 21'(h_adj) * 21'sd24 + 21'(h_adj >> 2) + 21'(l_adj >> 2) +
          21'(month_base(mo)) + 21'(dd) - 21'sd1 - EpochDays;
    info.ok = shape && alldig && ((yh != 7'd0) || (yl != 7'd0)) &&
              (mo >= 7'd1) && (mo <= 7'd12) && (dd >= 7'd1) &&
              (dd <= 7'(month_days(mo, leap))) && (hh <= 7'd23) &&
              (mi <= 7'd59) && (ss <= 7'd59);
    info.yr_hi   = h_adj;
    info.yr_lo   = l_adj;
    info.day_adj = adj;
    info.hour    = hh[4:0];
    info.minute  = mi[5:0];
    info.second  = ss[5:0];
  end

endmodule

@@ sv/lts_mac.sv @@
// Shared multiply-add unit: acc * k + add.
module lts_mac (
  input  logic signed [63:0] acc,
  input  logic [9:0]         k,
  input  logic signed [20:0] add,
  output logic signed [63:0] res
);
  logic signed [74:0] prod;

  assign prod = acc * $signed({1'b0, k});
  assign res  = prod[63:0] + 64'(add);

endmodule

@@ sv/log_timestamp_scanner_unit.sv @@
// Top level: log timestamp scanner, byte window search and date conversion.
//
//   channel     dir  payload                     request
//   text_in     in   text_byte[7:0], line_end    one text byte
//   result_out  out  found, timestamp_us[58:0]   one result per line
//
// A byte is taken in the idle state; when the window is full and searching, a check step follows it.
// A matching window then runs the conversion steps on the shared multiply-add unit.
// The last byte of a line leads to a result step that forms the result.
// Synchronous reset clears the line state; no clearing pass.
// A stalled result holds the block in its result step only.
module log_timestamp_scanner_unit (
  input  logic clk,
  input  logic rst,
  lts_in_if.sink    text_in,
  lts_out_if.source result_out
);
  import lts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_CONV, S_FIN} state_t;
  typedef enum logic [1:0] {PH_SEARCH, PH_MATCHED, PH_FRACTION, PH_DONE} phase_t;

  state_t              state;
  phase_t              phase;
  byte_t               window [WinLen];
  logic [4:0]          count;
  logic [2:0]          fdig;
  logic [19:0]         fval;
  logic signed [63:0]  acc;
  logic [2:0]          step;
  logic                pend_last;
  date_info_t          info;
  logic [9:0]          mk;
  logic signed [20:0]  madd;
  logic signed [63:0]  mres;
  logic [39:0]         pad;
  logic signed [63:0]  total;
  logic                accept, is_dig;
  logic [4:0]          count_next;

  lts_date_check u_date (.win(window), .info(info));
  lts_mac u_mac (.acc(acc), .k(mk), .add(madd), .res(mres));

  assign text_in.ready = (state == S_IDLE);
  assign accept = text_in.valid && text_in.ready;
  assign is_dig = (text_in.text_byte >= ChZero) && (text_in.text_byte <= ChNine);
  assign count_next = (count < 5'(WinLen)) ? count + 5'd1 : count;
  assign pad = fval * frac_scale(fdig);
  assign total = acc + 64'(pad);

  always_comb begin
    mk = 10'd0;
    madd = 21'sd0;
    case (step)
      3'd0: begin mk = 10'd0;    madd = 21'(info.yr_hi); end
      3'd1: begin mk = 10'd100;  madd = 21'(info.yr_lo); end
      3'd2: begin mk = 10'd365;  madd = info.day_adj; end
      3'd3: begin mk = 10'd24;   madd = 21'(info.hour); end
      3'd4: begin mk = 10'd60;   madd = 21'(info.minute); end
      3'd5: begin mk = 10'd60;   madd = 21'(info.second); end
      default: begin mk = 10'd1000; madd = 21'sd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_SEARCH;
      count <= 5'd0;
      fdig <= 3'd0;
      fval <= 20'd0;
      acc <= 64'sd0;
      step <= 3'd0;
      pend_last <= 1'b0;
      result_out.valid <= 1'b0;
      result_out.found <= 1'b0;
      result_out.timestamp_us <= 59'sd0;
      for (int i = 0; i < WinLen; i++) window[i] <= 8'd0;
    end else begin
      if (result_out.valid && result_out.ready && state != S_FIN)
        result_out.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_last <= text_in.line_end;
            state <= (phase == PH_SEARCH && count_next >= 5'(WinLen)) ? S_CHECK :
                     (text_in.line_end ? S_FIN : S_IDLE);
            case (phase)
              PH_SEARCH: begin
                for (int i = 0; i < WinLen - 1; i++) window[i] <= window[i+1];
                window[WinLen-1] <= text_in.text_byte;
                count <= count_next;
              end
              PH_MATCHED: phase <= (text_in.text_byte == ChDot) ? PH_FRACTION : PH_DONE;
              PH_FRACTION: begin
                if (fdig < 3'(FracMax) && is_dig) begin
                  fval <= 20'(fval * 20'd10) + 20'(text_in.text_byte - ChZero);
                  fdig <= fdig + 3'd1;
                  if (fdig + 3'd1 >= 3'(FracMax)) phase <= PH_DONE;
                end else begin
                  phase <= PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (info.ok) begin
            phase <= PH_MATCHED;
            acc <= 64'sd0;
            step <= 3'd0;
            state <= S_CONV;
          end else begin
            state <= pend_last ? S_FIN : S_IDLE;
          end
        end
        S_CONV: begin
          acc <= mres;
          step <= step + 3'd1;
          if (step == 3'd7) state <= pend_last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!result_out.valid || result_out.ready) begin
            result_out.valid <= 1'b1;
            result_out.found <= (phase != PH_SEARCH);
            result_out.timestamp_us <= (phase != PH_SEARCH) ? total[58:0] : 59'sd0;
            for (int i = 0; i < WinLen; i++) window[i] <= 8'd0;
            count <= 5'd0;
            phase <= PH_SEARCH;
            fdig <= 3'd0;
            fval <= 20'd0;
            acc <= 64'sd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.found) |-> (result_out.timestamp_us == 59'sd0))
    else $error("timestamp not zero without a match");

  a_result_needs_line_end: assert property (@(posedge clk) disable iff (rst)
    (text_in.valid && text_in.ready && !text_in.line_end) |=> !$rose(result_out.valid))
    else $error("result raised without a line end");

  a_conv_quiet_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && step != 3'd7) |=> (state == S_CONV && !text_in.ready))
    else $error("conversion sequence cut short");

endmodule

@@ dv/log_timestamp_scanner_unit_tb.sv @@
// Testbench: log timestamp scanner, directed and random lines checked against a line-level predictor.
module log_timestamp_scanner_unit_tb;
  import lts_pkg::*;

  typedef struct packed {
    logic               found;
    logic signed [58:0] timestamp_us;
  } stamp_t;

  localparam int CycleLimit = 400000;
  localparam int ErrShow    = 10;

  logic clk;
  logic rst;
  lts_in_if  text_in ();
  lts_out_if result_out ();

  log_timestamp_scanner_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .result_out(result_out)
  );

  // predictor state
  byte_t       win_q[WinLen];
  int          line_cnt;
  int          phase_q;
  int          frac_cnt;
  int          frac_val;
  longint      whole_us;
  stamp_t      stamp_q[$];

  int  err_cnt;
  int  cycle_cnt;
  bit  idle_on;

  localparam int PhSearch = 0;
  localparam int PhMatched = 1;
  localparam int PhFraction = 2;
  localparam int PhDone = 3;

  function automatic bit is_digit(byte_t c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic int field_val(int pos, int n);
    int v;
    v = 0;
    for (int i = 0; i < n; i++) begin
      if (!is_digit(win_q[pos + i])) return -1;
      v = v * 10 + int'(win_q[pos + i] - ChZero);
    end
    return v;
  endfunction

  function automatic longint days_from_epoch(int y, int m, int d);
    longint yy, era, yoe, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic bit window_hit();
    int y, mo, d, h, mi, s, lim;
    if (win_q[4] != ChDash || win_q[7] != ChDash || win_q[10] != ChSpace ||
        win_q[13] != ChColon || win_q[16] != ChColon) return 0;
    y = field_val(0, 4); mo = field_val(5, 2); d = field_val(8, 2);
    h = field_val(11, 2); mi = field_val(14, 2); s = field_val(17, 2);
    if (y < 1 || mo < 1 || mo > 12 || d < 1 || h < 0 || h > 23 ||
        mi < 0 || mi > 59 || s < 0 || s > 59) return 0;
    case (mo)
      2: lim = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11: lim = 30;
      default: lim = 31;
    endcase
    if (d > lim) return 0;
    whole_us = (days_from_epoch(y, mo, d) * 86400 + longint'(h) * 3600 +
                longint'(mi) * 60 + s) * 1000000;
    return 1;
  endfunction

  function automatic void clear_line();
    foreach (win_q[i]) win_q[i] = '0;
    line_cnt = 0; phase_q = PhSearch; frac_cnt = 0; frac_val = 0; whole_us = 0;
  endfunction

  function automatic void predict_byte(byte_t c, bit last);
    stamp_t st;
    longint f;
    case (phase_q)
      PhSearch: begin
        for (int i = 0; i < WinLen - 1; i++) win_q[i] = win_q[i + 1];
        win_q[WinLen - 1] = c;
        if (line_cnt < WinLen) line_cnt++;
        if (line_cnt >= WinLen && window_hit()) phase_q = PhMatched;
      end
      PhMatched: phase_q = (c == ChDot) ? PhFraction : PhDone;
      PhFraction: begin
        if (frac_cnt < FracMax && is_digit(c)) begin
          frac_val = frac_val * 10 + int'(c - ChZero);
          frac_cnt++;
          if (frac_cnt >= FracMax) phase_q = PhDone;
        end else begin
          phase_q = PhDone;
        end
      end
      default: ;
    endcase
    if (!last) return;
    if (phase_q == PhSearch) begin
      st = '0;
    end else begin
      f = frac_val;
      for (int k = frac_cnt; k < FracMax; k++) f *= 10;
      st.found = 1'b1;
      st.timestamp_us = 59'(whole_us + f);
    end
    stamp_q.insert(stamp_q.size(), st);
    clear_line();
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("log_timestamp_scanner_unit_tb: done, errors");
      $finish;
    end
  end

  // result side: random stalls, checking
  int stall_left;
  always @(posedge clk) begin
    stamp_t exp_s;
    if (rst) begin
      result_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (stamp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ErrShow) $display("unexpected result found=%0b ts=%0d",
                                          result_out.found, result_out.timestamp_us);
        end else begin
          exp_s = stamp_q.pop_front();
          if (exp_s.found !== result_out.found ||
              exp_s.timestamp_us !== result_out.timestamp_us) begin
            err_cnt++;
            if (err_cnt <= ErrShow)
              $display("mismatch: exp found=%0b ts=%0d, got found=%0b ts=%0d",
                       exp_s.found, exp_s.timestamp_us,
                       result_out.found, result_out.timestamp_us);
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
      result_out.ready <= (stall_left == 0);
    end
  end

  task automatic send_byte(byte_t c, bit last);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      text_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.text_byte <= c;
    text_in.line_end  <= last;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    predict_byte(c, last);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]), i == s.len() - 1);
  endtask

  task automatic drain();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (stamp_q.size() != 0) @(posedge clk);
  endtask

  function automatic string rand_stamp(bit valid_only);
    int y, mo, d;
    y = $urandom_range(0, 3) == 0 ? $urandom_range(1, 9999) : $urandom_range(1900, 2100);
    mo = valid_only ? $urandom_range(1, 12) : $urandom_range(0, 13);
    d = valid_only ? $urandom_range(1, 28) : $urandom_range(0, 32);
    if (!valid_only && $urandom_range(0, 3) == 0) d = 29 + $urandom_range(0, 1);
    return $sformatf("%04d-%02d-%02d %02d:%02d:%02d", y, mo, d,
                     valid_only ? $urandom_range(0, 23) : $urandom_range(0, 25),
                     valid_only ? $urandom_range(0, 59) : $urandom_range(0, 61),
                     valid_only ? $urandom_range(0, 59) : $urandom_range(0, 61));
  endfunction

  function automatic string rand_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
      else s = {s, string'(byte'($urandom_range(32, 126)))};
    end
    return s;
  endfunction

  task automatic test_extremes();
    send_line("0001-01-01 00:00:00");
    send_line("9999-12-31 23:59:59.999999");
    send_line("1970-01-01 00:00:00.5");
    send_line("1969-12-31 23:59:59.");
    send_line("2000-02-29 12:00:00.1234567x");
    send_line("1900-02-29 12:00:00");
    send_line("2024-02-29 08:30:15.25 tail");
    send_line("0000-01-01 00:00:00");
    send_line("2023-13-01 00:00:00");
    send_line("2023-04-31 00:00:00");
    send_line("2023-01-01 24:00:00");
    send_line("2023-01-01 23:60:00");
    send_line("2023-01-01 23:59:60");
    send_line("20a3-01-01 00:00:00");
    send_line("short");
    send_byte(8'hff, 1'b1);
    send_line("xx2023-06-30 10:20:30 2023-07-01 00:00:00");
    send_line("2023-06-31 10:20:30 2023-07-01 01:02:03.4");
    send_line("2021-03-04 05:06:07x.1");
    drain();
  endtask

  task automatic test_all_bytes();
    // every byte value and both line_end values
    for (int i = 0; i < 256; i++) send_byte(byte_t'(i), (i % 40) == 39);
    send_byte(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_random(int n_lines);
    string s;
    for (int i = 0; i < n_lines; i++) begin
      case ($urandom_range(0, 5))
        0: s = rand_text($urandom_range(1, 30));
        1: s = {rand_text($urandom_range(0, 4)), rand_stamp(0), rand_text($urandom_range(0, 3))};
        default: begin
          s = {rand_text($urandom_range(0, 4)), rand_stamp(1)};
          if ($urandom_range(0, 2) != 0)
            s = {s, ".", $sformatf("%0d", $urandom_range(0, 9999999))};
          if ($urandom_range(0, 1)) s = {s, rand_text($urandom_range(1, 4))};
        end
      endcase
      send_line(s);
    end
    drain();
  endtask

  initial begin
    err_cnt = 0; cycle_cnt = 0; idle_on = 1;
    clear_line();
    rst = 1'b1;
    text_in.valid <= 1'b0;
    text_in.text_byte <= '0;
    text_in.line_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_all_bytes();
    test_random(16);
    idle_on = 0;
    test_random(6);
    repeat (30) @(posedge clk);
    if (err_cnt == 0 && stamp_q.size() == 0) begin
      $display("log_timestamp_scanner_unit_tb: done, clean");
    end else begin
      $display("log_timestamp_scanner_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lts_pkg.sv
sv/lts_if.sv
sv/lts_date_check.sv
sv/lts_mac.sv
sv/log_timestamp_scanner_unit.sv
dv/log_timestamp_scanner_unit_tb.sv
